// ===== sv/wildcard_byte_pattern_scanner_macros.svh =====
// Assertion macros used by the scanner front end.
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_MACROS_SVH

`ifndef SYNTHESIS

// Plain property, checked at every edge outside reset.
`define WBPS_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("wbps assertion failed");

// Same-cycle implication.
`define WBPS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wbps implication failed");

// Next-cycle implication.
`define WBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wbps next-cycle implication failed");

`else

`define WBPS_ASSERT(label, clk, rst_n, prop)
`define WBPS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define WBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/wbps_pkg.sv =====
// Types and constants of the wildcard byte pattern scanner.
package wbps_pkg;

	localparam int MAX_PATTERN_DEF = 16;
	localparam int OFFSET_BITS_DEF = 32;
	localparam int PATTERN_SLOTS   = 16;
	localparam int WINDOW_DEPTH    = 15;
	localparam int QUEUE_DEPTH     = 2;
	localparam int CFG_DATA_W      = 64;
	localparam int CFG_INDEX_W     = 2;
	localparam int LENGTH_W        = 5;
	localparam int MATCH_OFFSET_W  = 32;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PATTERN_LOW  = 2'd0,
		REG_PATTERN_HIGH = 2'd1,
		REG_WILDCARD     = 2'd2,
		REG_LENGTH       = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [7:0] image_byte;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic                      found;
		logic [MATCH_OFFSET_W-1:0] match_offset;
	} out_t;

	typedef struct packed {
		logic [8*PATTERN_SLOTS-1:0] pattern_data;
		logic [PATTERN_SLOTS-1:0]   wildcard_bits;
		logic [LENGTH_W-1:0]        pattern_length;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic valid;
	} q_status_t;

endpackage

// ===== sv/wildcard_byte_pattern_scanner.sv =====
// Top level of the wildcard byte pattern scanner: config registers and the three stages.
// Throughput: one image byte per cycle unless the result queue is full.
// The front end compares the whole window combinationally; a result is written to the queue
//   at the edge that takes the byte causing it, then loaded into the output register.
// The input stalls only while the two-entry result queue is full.
// Reset (async, active low): window, count and queue clear; pattern zero, length one.
module wildcard_byte_pattern_scanner #(
	parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF,
	parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// image byte channel
	input  logic                            image_valid,
	output logic                            image_stall,
	input  wbps_pkg::in_t                   image_beat,
	// result channel
	output logic                            result_valid,
	input  logic                            result_stall,
	output wbps_pkg::out_t                  result_beat,
	// configuration writes
	input  logic                            cfg_we,
	input  logic [wbps_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic [wbps_pkg::CFG_DATA_W-1:0]    pattern_low_q;
	logic [wbps_pkg::CFG_DATA_W-1:0]    pattern_high_q;
	logic [wbps_pkg::PATTERN_SLOTS-1:0] wildcard_q;
	logic [wbps_pkg::LENGTH_W-1:0]      length_q;

	wbps_pkg::cfg_t      cfg;
	wbps_pkg::q_status_t q_status;
	wbps_pkg::out_t      push_beat;
	wbps_pkg::out_t      head_beat;
	logic                push;
	logic                pop;

	// Config is only written while no byte is in flight, so the front end reads
	// these registers directly; the user must keep to this, the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q  <= '0;
			pattern_high_q <= '0;
			wildcard_q     <= '0;
			length_q       <= wbps_pkg::LENGTH_W'(1);
		end else if (cfg_we) begin
			case (wbps_pkg::reg_index_t'(cfg_index))
				wbps_pkg::REG_PATTERN_LOW:  pattern_low_q  <= cfg_data;
				wbps_pkg::REG_PATTERN_HIGH: pattern_high_q <= cfg_data;
				wbps_pkg::REG_WILDCARD:
					wildcard_q <= cfg_data[wbps_pkg::PATTERN_SLOTS-1:0];
				wbps_pkg::REG_LENGTH:
					length_q <= cfg_data[wbps_pkg::LENGTH_W-1:0];
				default: ;
			endcase
		end
	end

	// byte 0 sits in the low bits of the low register, byte 8 in the high one
	assign cfg.pattern_data   = {pattern_high_q, pattern_low_q};
	assign cfg.wildcard_bits  = wildcard_q;
	assign cfg.pattern_length = length_q;

	// Front end: window shift, byte count, match and end-of-image decision.
	wbps_front #(
		.MAX_PATTERN(MAX_PATTERN),
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.image_valid(image_valid),
		.image_stall(image_stall),
		.image_beat (image_beat),
		.cfg        (cfg),
		.q_status   (q_status),
		.push       (push),
		.push_beat  (push_beat)
	);

	// Decoupling queue: lets the front keep taking bytes while a result waits.
	wbps_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_beat(push_beat),
		.pop      (pop),
		.head_beat(head_beat),
		.status   (q_status)
	);

	// Back end: registered result beat toward the consumer.
	wbps_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_status    (q_status),
		.head_beat   (head_beat),
		.pop         (pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_beat (result_beat)
	);

endmodule

// ===== sv/wbps_front.sv =====
// Front end: takes image bytes, keeps the byte window and count, classifies each beat.
`include "wildcard_byte_pattern_scanner_macros.svh"

module wbps_front #(
	parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF,
	parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                image_valid,
	output logic                image_stall,
	input  wbps_pkg::in_t       image_beat,
	input  wbps_pkg::cfg_t      cfg,
	input  wbps_pkg::q_status_t q_status,
	output logic                push,
	output wbps_pkg::out_t      push_beat
);

	localparam int LIMIT = (MAX_PATTERN < wbps_pkg::PATTERN_SLOTS) ?
		MAX_PATTERN : wbps_pkg::PATTERN_SLOTS;
	localparam int LW = wbps_pkg::LENGTH_W;
	localparam int PS = wbps_pkg::PATTERN_SLOTS;

	logic [7:0]             recent_q [wbps_pkg::WINDOW_DEPTH];
	logic [OFFSET_BITS-1:0] byte_count_q;
	logic                   reported_q;

	logic                   accept;
	logic [LW-1:0]          eff_len;
	logic [PS-1:0]          lane_ok;
	logic                   hit;
	logic                   not_sat;
	logic                   enough;
	logic [OFFSET_BITS-1:0] len_m1;
	logic [OFFSET_BITS-1:0] start_off;

	assign image_stall = q_status.full;
	assign accept      = image_valid && !q_status.full;

	// zero reads as one, oversize clips to the slot limit
	always_comb begin
		eff_len = cfg.pattern_length;
		if (cfg.pattern_length == '0) begin
			eff_len = LW'(1);
		end else if (cfg.pattern_length > LW'(LIMIT)) begin
			eff_len = LW'(LIMIT);
		end
	end

	// lane b looks b bytes back; it faces pattern byte len-1-b
	for (genvar b = 0; b < PS; b++) begin : g_lane
		logic [3:0] pj;
		logic [7:0] tap;
		assign pj = 4'(eff_len - LW'(b) - LW'(1));
		if (b == 0) begin : g_cur
			assign tap = image_beat.image_byte;
		end else begin : g_old
			assign tap = recent_q[b-1];
		end
		assign lane_ok[b] = (LW'(b) >= eff_len) || cfg.wildcard_bits[pj] ||
			(tap == cfg.pattern_data[{pj, 3'b000} +: 8]);
	end

	assign len_m1    = OFFSET_BITS'(eff_len - LW'(1));
	assign not_sat   = (byte_count_q != '1);
	assign enough    = (byte_count_q >= len_m1);
	assign start_off = byte_count_q - len_m1;
	assign hit       = !reported_q && not_sat && enough && (&lane_ok);

	// one result at most: the first hit, or a miss on the final byte
	assign push = accept && !reported_q && (hit || image_beat.last_byte);
	always_comb begin
		push_beat.found        = hit;
		push_beat.match_offset = hit ? wbps_pkg::MATCH_OFFSET_W'(start_off) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			reported_q   <= 1'b0;
			for (int i = 0; i < wbps_pkg::WINDOW_DEPTH; i++) begin
				recent_q[i] <= '0;
			end
		end else if (accept) begin
			if (image_beat.last_byte) begin
				byte_count_q <= '0;
				reported_q   <= 1'b0;
				for (int i = 0; i < wbps_pkg::WINDOW_DEPTH; i++) begin
					recent_q[i] <= '0;
				end
			end else begin
				if (not_sat) begin
					byte_count_q <= byte_count_q + OFFSET_BITS'(1);
				end
				if (hit) begin
					reported_q <= 1'b1;
				end
				recent_q[0] <= image_beat.image_byte;
				for (int i = 1; i < wbps_pkg::WINDOW_DEPTH; i++) begin
					recent_q[i] <= recent_q[i-1];
				end
			end
		end
	end

	`WBPS_ASSERT_NEXT(a_last_clears, clk, arst_n, accept && image_beat.last_byte, (byte_count_q == '0) && !reported_q)
	`WBPS_ASSERT_IMPL(a_miss_on_last, clk, arst_n, push && !push_beat.found, image_beat.last_byte)
	`WBPS_ASSERT_IMPL(a_flag_from_hit, clk, arst_n, $rose(reported_q), $past(push && push_beat.found))
	`WBPS_ASSERT_NEXT(a_count_monotonic, clk, arst_n, !(accept && image_beat.last_byte), byte_count_q >= $past(byte_count_q))

endmodule

// ===== sv/wbps_queue.sv =====
// Short result queue between front and back ends.
module wbps_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  wbps_pkg::out_t      push_beat,
	input  logic                pop,
	output wbps_pkg::out_t      head_beat,
	output wbps_pkg::q_status_t status
);

	localparam int DEPTH = wbps_pkg::QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	wbps_pkg::out_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign status.full  = (count_q == CW'(DEPTH));
	assign status.valid = (count_q != '0);
	assign head_beat    = mem_q[rd_ptr_q];
	assign do_push      = push && !status.full;
	assign do_pop       = pop && status.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/wbps_back.sv =====
// Back end: drains the queue into the registered result port.
module wbps_back (
	input  logic                clk,
	input  logic                arst_n,
	input  wbps_pkg::q_status_t q_status,
	input  wbps_pkg::out_t      head_beat,
	output logic                pop,
	output logic                result_valid,
	input  logic                result_stall,
	output wbps_pkg::out_t      result_beat
);

	logic           valid_q;
	wbps_pkg::out_t beat_q;

	// refill when the output slot is empty or being taken
	assign pop          = q_status.valid && (!valid_q || !result_stall);
	assign result_valid = valid_q;
	assign result_beat  = beat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			beat_q <= head_beat;
		end
	end

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench of the wildcard byte pattern scanner.
module tb_top;

	// Cycles to let pass after the last expected result before a register write
	// or the final verdict.
	localparam int DRAIN_CYCLES = 4;
	// Random part: register settings and image bytes per setting.
	localparam int SETTINGS_N = 20;
	localparam int BYTES_PER_SETTING = 64;
	// Length of the output hold-off that fills the result queue.
	localparam int HOLD_OFF_CYCLES = 300;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             image_valid = 1'b0;
	logic                             image_stall;
	wbps_pkg::in_t                    image_beat = '0;
	logic                             result_valid;
	logic                             result_stall = 1'b0;
	wbps_pkg::out_t                   result_beat;
	logic                             cfg_we = 1'b0;
	logic [wbps_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

	wildcard_byte_pattern_scanner dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.image_valid  (image_valid),
		.image_stall  (image_stall),
		.image_beat   (image_beat),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_beat  (result_beat),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// ------------------------------------------------------------------
	// Scanner shadow: register copies and scan state, updated per beat.
	// ------------------------------------------------------------------
	logic [8*wbps_pkg::PATTERN_SLOTS-1:0] pat_bytes = '0;  // byte k at bits 8k+7:8k
	logic [wbps_pkg::PATTERN_SLOTS-1:0]   wild_mask = '0;
	logic [wbps_pkg::LENGTH_W-1:0]        len_reg = 5'd1;
	logic [7:0]                           win_bytes [wbps_pkg::WINDOW_DEPTH];  // 0 = newest
	logic [31:0]                          bytes_in_image = '0;
	bit                                   hit_reported = 1'b0;

	wbps_pkg::out_t pending_results [$];  // predicted results, oldest first

	// Knobs shared with the receiver process.
	int idle_pct = 0;    // chance per cycle that the sender holds back
	int stall_pct = 0;   // chance per cycle that the receiver stalls
	int hold_left = 0;   // forced receiver stall, counted down per cycle

	int mismatches = 0;
	int bytes_sent = 0;
	int images_sent = 0;
	int results_checked = 0;
	int settings_applied = 0;

	// Directed stimulus table.
	typedef enum logic [1:0] {ROW_SETUP, ROW_BYTE, ROW_CHECKED} row_kind_t;
	typedef struct {
		row_kind_t      kind;
		logic [63:0]    lo;
		logic [63:0]    hi;
		logic [15:0]    wild;
		logic [4:0]     len;
		wbps_pkg::in_t  beat;
		wbps_pkg::out_t want;  // typed-in result, ROW_CHECKED only
	} scan_row_t;

	scan_row_t directed_rows [$];

	initial begin : clock_gen
		forever #5 clk = ~clk;
	end

	task automatic log_mismatch(input string what);
		mismatches++;
		$display("tb_top: MISMATCH at %0t: %s", $realtime, what);
	endtask

	// Pattern length as the block uses it: zero reads as one, above the
	// slot count saturates.
	function automatic int unsigned used_length();
		int unsigned n;
		n = len_reg;
		if (n == 0)
			n = 1;
		if (n > wbps_pkg::PATTERN_SLOTS)
			n = wbps_pkg::PATTERN_SLOTS;
		return n;
	endfunction

	function automatic void clear_scan_state();
		foreach (win_bytes[k])
			win_bytes[k] = 8'h00;
		bytes_in_image = '0;
		hit_reported = 1'b0;
	endfunction

	// Advances the shadow by one accepted byte; returns 1 with the result
	// when this byte produces one.
	function automatic bit scan_predict(input logic [7:0] cur, input bit is_last,
	                                    output wbps_pkg::out_t res);
		int unsigned     eff;
		int unsigned     back;
		longint unsigned seen;
		logic [7:0]      b;
		bit              hit;
		bit              produced;
		eff = used_length();
		produced = 1'b0;
		res = '0;
		if (!hit_reported && bytes_in_image != 32'hFFFF_FFFF) begin
			seen = bytes_in_image + 64'd1;
			if (seen >= eff) begin
				hit = 1'b1;
				for (int j = 0; j < eff; j++) begin
					back = eff - 1 - j;
					b = (back == 0) ? cur : win_bytes[back - 1];
					if (!wild_mask[j] && b != pat_bytes[8*j +: 8])
						hit = 1'b0;
				end
				if (hit) begin
					res.found = 1'b1;
					res.match_offset = 32'(seen - eff);
					hit_reported = 1'b1;
					produced = 1'b1;
				end
			end
		end
		for (int k = wbps_pkg::WINDOW_DEPTH - 1; k > 0; k--)
			win_bytes[k] = win_bytes[k - 1];
		win_bytes[0] = cur;
		if (bytes_in_image != 32'hFFFF_FFFF)
			bytes_in_image++;
		if (is_last) begin
			if (!hit_reported) begin
				res = '0;
				produced = 1'b1;
			end
			clear_scan_state();
		end
		return produced;
	endfunction

	// ------------------------------------------------------------------
	// Driving. Called at a falling edge, returns at a falling edge.
	// ------------------------------------------------------------------
	// One image beat: random gaps first, then hold the beat until taken.
	// A typed row always expects its typed result.
	task automatic send_byte(input wbps_pkg::in_t beat, input bit typed,
	                         input wbps_pkg::out_t typed_want);
		wbps_pkg::out_t predicted;
		bit             produced;
		while ($urandom_range(99) < idle_pct) begin
			image_valid <= 1'b0;
			@(negedge clk);
		end
		image_valid <= 1'b1;
		image_beat <= beat;
		do
			@(posedge clk);
		while (image_stall);
		// Beat taken at this edge.
		produced = scan_predict(beat.image_byte, beat.last_byte, predicted);
		if (typed)
			pending_results.insert(pending_results.size(), typed_want);
		else if (produced)
			pending_results.insert(pending_results.size(), predicted);
		bytes_sent++;
		if (beat.last_byte)
			images_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(input wbps_pkg::reg_index_t idx,
	                         input logic [wbps_pkg::CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
	endtask

	// Waits for the block to go quiet, then writes all four registers.
	task automatic reconfigure(input logic [63:0] lo, input logic [63:0] hi,
	                           input logic [15:0] wild, input logic [4:0] len);
		image_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		// A last byte after a reported match gives no result: let it settle.
		repeat (DRAIN_CYCLES) @(negedge clk);
		write_reg(wbps_pkg::REG_PATTERN_LOW, lo);
		write_reg(wbps_pkg::REG_PATTERN_HIGH, hi);
		write_reg(wbps_pkg::REG_WILDCARD, {48'h0, wild});
		write_reg(wbps_pkg::REG_LENGTH, {59'h0, len});
		cfg_we <= 1'b0;
		pat_bytes = {hi, lo};
		wild_mask = wild;
		len_reg = len;
		settings_applied++;
	endtask

	// Random byte: half fully random, half drawn from the active pattern so
	// that partial and accidental matches are common.
	function automatic logic [7:0] pick_byte(input int unsigned eff);
		if ($urandom_range(1))
			return 8'($urandom_range(255));
		return pat_bytes[8*$urandom_range(eff - 1) +: 8];
	endfunction

	// One whole image. Most carry a planted copy of the pattern (wildcard
	// slots filled at random), some with one byte spoiled; the rest are noise.
	// About one in five is no longer than the pattern.
	task automatic send_image();
		int unsigned   eff;
		int unsigned   n;
		int unsigned   at;
		int unsigned   spoil_at;
		int unsigned   j;
		bit            plant;
		bit            spoil;
		wbps_pkg::in_t beat;
		eff = used_length();
		if ($urandom_range(99) < 20)
			n = $urandom_range(eff, 1);
		else
			n = $urandom_range(eff + 24, eff);
		plant = ($urandom_range(99) < 65) && (n >= eff);
		at = plant ? $urandom_range(n - eff) : 0;
		spoil = plant && ($urandom_range(99) < 25);
		spoil_at = $urandom_range(eff - 1);
		for (int unsigned k = 0; k < n; k++) begin
			if (plant && k >= at && k < at + eff) begin
				j = k - at;
				beat.image_byte = wild_mask[j] ? pick_byte(eff) : pat_bytes[8*j +: 8];
				if (spoil && j == spoil_at)
					beat.image_byte = ~beat.image_byte;
			end else begin
				beat.image_byte = pick_byte(eff);
			end
			beat.last_byte = (k == n - 1);
			send_byte(beat, 1'b0, '0);
		end
	endtask

	// Table builders.
	function automatic void add_setup(input logic [63:0] lo, input logic [63:0] hi,
	                                  input logic [15:0] wild, input logic [4:0] len);
		scan_row_t r;
		r = '{kind: ROW_SETUP, lo: lo, hi: hi, wild: wild, len: len, beat: '0, want: '0};
		directed_rows.insert(directed_rows.size(), r);
	endfunction

	function automatic void add_byte(input logic [7:0] b, input bit is_last);
		scan_row_t r;
		r = '{kind: ROW_BYTE, lo: '0, hi: '0, wild: '0, len: '0, beat: '0, want: '0};
		r.beat.image_byte = b;
		r.beat.last_byte = is_last;
		directed_rows.insert(directed_rows.size(), r);
	endfunction

	function automatic void add_checked(input logic [7:0] b, input bit is_last,
	                                    input bit found, input logic [31:0] offset);
		scan_row_t r;
		r = '{kind: ROW_CHECKED, lo: '0, hi: '0, wild: '0, len: '0, beat: '0, want: '0};
		r.beat.image_byte = b;
		r.beat.last_byte = is_last;
		r.want.found = found;
		r.want.match_offset = offset;
		directed_rows.insert(directed_rows.size(), r);
	endfunction

	// ------------------------------------------------------------------
	// Receiver: random stalls, plus a forced hold-off when hold_left is set.
	// ------------------------------------------------------------------
	initial begin : result_sink
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				result_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Checker: every taken result against the oldest prediction.
	always @(posedge clk) begin
		wbps_pkg::out_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				log_mismatch($sformatf("result with none expected: found=%0b offset=%0d",
				                       result_beat.found, result_beat.match_offset));
			end else begin
				want = pending_results.pop_front();
				if (result_beat.found !== want.found)
					log_mismatch($sformatf("found %0b, expected %0b",
					                       result_beat.found, want.found));
				if (result_beat.match_offset !== want.match_offset)
					log_mismatch($sformatf("match_offset %0d, expected %0d",
					                       result_beat.match_offset, want.match_offset));
				results_checked++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------
	initial begin : stimulus
		logic [63:0] lo;
		logic [63:0] hi;
		logic [15:0] wild;
		logic [4:0]  len;
		int          phase_start;

		clear_scan_state();

		// Reset state: length one, pattern byte zero.
		add_checked(8'h00, 1'b0, 1'b1, 32'd0);
		add_byte(8'hFF, 1'b1);                  // already reported: silent last
		// Pattern AA 00 FF, no wildcards.
		add_setup(64'h0000_0000_00FF_00AA, 64'h0, 16'h0000, 5'd3);
		add_byte(8'h11, 1'b0);
		add_byte(8'hAA, 1'b0);
		add_byte(8'h00, 1'b0);
		add_checked(8'hFF, 1'b1, 1'b1, 32'd1);  // match ends on the last byte
		add_checked(8'hAA, 1'b1, 1'b0, 32'd0);  // image shorter than pattern
		// Length zero reads as one.
		add_setup(64'h0000_0000_0000_00AA, 64'h0, 16'h0000, 5'd0);
		add_byte(8'h55, 1'b0);
		add_checked(8'hAA, 1'b1, 1'b1, 32'd1);
		// Length 31 saturates to 16; all slots wild but the top one (FF).
		add_setup('1, '1, 16'h7FFF, 5'd31);
		for (int k = 0; k < 15; k++)
			add_byte(k[0] ? 8'hFF : 8'h00, 1'b0);
		add_checked(8'hFF, 1'b1, 1'b1, 32'd0);

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			case (directed_rows[i].kind)
				ROW_SETUP: begin
					reconfigure(directed_rows[i].lo, directed_rows[i].hi,
					            directed_rows[i].wild, directed_rows[i].len);
				end
				ROW_BYTE: begin
					send_byte(directed_rows[i].beat, 1'b0, '0);
				end
				default: begin
					send_byte(directed_rows[i].beat, 1'b1, directed_rows[i].want);
				end
			endcase
		end

		// Random part: a fresh register setting per phase, idling pattern
		// rotating through none / sender / receiver / both.
		for (int p = 0; p < SETTINGS_N; p++) begin
			case (p % 6)
				0: len = 5'd16;
				1: len = 5'd1;
				2: len = (p % 12 == 2) ? 5'd0 : 5'd31;
				3: len = 5'($urandom_range(31, 17));
				default: len = 5'($urandom_range(16, 1));
			endcase
			case ($urandom_range(3))
				0: wild = 16'h0000;
				1: wild = 16'hFFFF;
				2: wild = 16'($urandom);
				default: wild = 16'($urandom & $urandom);  // sparse
			endcase
			case ($urandom_range(9))
				0: begin
					lo = '1;
					hi = '1;
				end
				1: begin
					lo = '0;
					hi = '0;
				end
				default: begin
					lo = {$urandom, $urandom};
					hi = {$urandom, $urandom};
				end
			endcase
			reconfigure(lo, hi, wild, len);

			case (p % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 60;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 60;
				end
				default: begin
					idle_pct = 6;
					stall_pct = 6;
				end
			endcase
			// Once: hold the output off while bytes keep coming, so the result
			// queue fills and the block stalls its input.
			if (p == 4)
				hold_left = HOLD_OFF_CYCLES;

			phase_start = bytes_sent;
			while (bytes_sent - phase_start < BYTES_PER_SETTING)
				send_image();
		end

		image_valid <= 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		for (int w = 0; w < 5000 && pending_results.size() != 0; w++)
			@(negedge clk);
		repeat (DRAIN_CYCLES * 2) @(negedge clk);
		if (pending_results.size() != 0)
			log_mismatch($sformatf("%0d expected results never arrived",
			                       pending_results.size()));

		$display("tb_top: %0d bytes in %0d images, %0d results checked, %0d settings",
		         bytes_sent, images_sent, results_checked, settings_applied);
		$display("tb_top: lengths 0..31, wild and exact slots, stalls and a long hold-off");
		if (mismatches == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin : watchdog
		#5_000_000;
		$display("tb_top: timeout");
		$display("tb_top: done, errors");
		$finish;
	end

endmodule
